// ----- hdl/crwt_pkg.sv -----
// Shared types and constants for the request credit window tracker.
package crwt_pkg;

    localparam int NUM_W    = 32;
    localparam int CREDIT_W = 16;
    localparam int WINDOW_W = 6;
    localparam int DELTA_W  = 8;
    localparam int RATE_W   = 3;

    localparam logic [WINDOW_W-1:0]        WINDOW_RESET = 6'd30;
    localparam logic signed [CREDIT_W-1:0] CREDIT_RESET = 16'sd30;
    localparam logic signed [CREDIT_W-1:0] CREDIT_MAX   = 16'sh7fff;
    localparam logic signed [CREDIT_W-1:0] CREDIT_MIN   = 16'sh8000;

    // operation codes carried on the input channel
    localparam logic [2:0] OP_REQUEST = 3'd0;
    localparam logic [2:0] OP_ARRIVE  = 3'd1;
    localparam logic [2:0] OP_MISS    = 3'd2;
    localparam logic [2:0] OP_ADJUST  = 3'd3;
    localparam logic [2:0] OP_RESTART = 3'd4;

    // commands to the outstanding pool
    typedef enum logic [1:0] {
        POOL_NOP     = 2'd0,
        POOL_CLAIM   = 2'd1,
        POOL_RELEASE = 2'd2,
        POOL_CLEAR   = 2'd3
    } t_pool_op;

    // status of one pool scan
    typedef struct packed {
        logic done;
        logic hit;
        logic free;
    } t_scan_flags;

endpackage

// ----- hdl/request_credit_window_tracker_core.sv -----
// Top level of the request credit window tracker: sequencer, credits and result register.
//
// Tracks outstanding requests under a credit window. Each transfer on the input channel
// carries one operation: request (spend a credit and record the packet number), arrival
// (retire a matching number and return a credit), miss (retire as for arrival, then file
// the number among the MISS_KEEP largest distinct misses and report count / spread),
// adjust (add a signed delta to the credits, saturating) or restart (empty the pool and
// reload the credits from the default window register). Codes 5 to 7 change nothing.
// Every input transfer yields exactly one output transfer. One item is worked on at a
// time. Outstanding numbers sit in a memory of POOL_DEPTH entries with one write port and
// one registered read port, scanned one entry per cycle; request, arrival and miss wait
// for the whole scan before their result, and a miss then adds a sorted insert and the
// bit-serial quotient. Adjust, restart and unused codes skip the scan. Pool writes land
// only after a scan has finished, so the next scan never meets a write in flight. The
// input side is ready again once the result is in the output register, even while that
// result is still stalled. Write the default window only with no item in progress.
module request_credit_window_tracker_core
    import crwt_pkg::*;
#(
    parameter int POOL_DEPTH = 32,
    parameter int MISS_KEEP  = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_we,
    input  logic [WINDOW_W-1:0]        i_cfg_wdata,
    // input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [2:0]                 i_operation,
    input  logic [NUM_W-1:0]           i_packet_number,
    input  logic signed [DELTA_W-1:0]  i_delta,
    // output channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_accepted,
    output logic signed [CREDIT_W-1:0] o_credits,
    output logic [RATE_W-1:0]          o_miss_rate
);

    localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_MISS = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                      r_state;
    logic [WINDOW_W-1:0]         r_default_window;
    logic signed [CREDIT_W-1:0]  r_credit;
    logic [2:0]                  r_op;
    logic [NUM_W-1:0]            r_num;
    logic                        r_acc;
    logic [RATE_W-1:0]           r_rate;
    logic                        r_o_valid;
    logic                        r_o_accepted;
    logic signed [CREDIT_W-1:0]  r_o_credits;
    logic [RATE_W-1:0]           r_o_miss_rate;

    logic                        accept;
    logic                        out_free;
    logic                        credit_pos;
    logic signed [CREDIT_W:0]    adj_sum;
    logic signed [CREDIT_W-1:0]  adj_sat;
    logic signed [CREDIT_W-1:0]  inc_sat;
    logic                        scan_start;
    logic                        miss_start;
    t_pool_op                    pool_cmd;
    logic [AW-1:0]               pool_idx;
    t_scan_flags                 scan;
    logic [AW-1:0]               hit_idx;
    logic [AW-1:0]               free_idx;
    logic                        miss_done;
    logic [RATE_W-1:0]           miss_rate;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    // result register can take a new result this cycle
    assign out_free = !r_o_valid || !i_stall;

    assign credit_pos = !r_credit[CREDIT_W-1] && (r_credit != '0);

    // saturating credit arithmetic; overflow shows as a sign mismatch in the wide sum
    assign adj_sum = {r_credit[CREDIT_W-1], r_credit}
                   + {{(CREDIT_W + 1 - DELTA_W){i_delta[DELTA_W-1]}}, i_delta};
    assign adj_sat = (adj_sum[CREDIT_W] != adj_sum[CREDIT_W-1])
                   ? (adj_sum[CREDIT_W] ? CREDIT_MIN : CREDIT_MAX)
                   : adj_sum[CREDIT_W-1:0];
    assign inc_sat = (r_credit == CREDIT_MAX) ? CREDIT_MAX : r_credit + CREDIT_W'(1);

    // pool commands: clear on restart, claim or release once the scan is in
    always_comb begin
        pool_cmd   = POOL_NOP;
        pool_idx   = hit_idx;
        scan_start = 1'b0;
        miss_start = 1'b0;
        if (accept) begin
            unique case (i_operation) inside
                OP_REQUEST, OP_ARRIVE, OP_MISS: scan_start = 1'b1;
                OP_RESTART:                     pool_cmd   = POOL_CLEAR;
                default:                        ;
            endcase
        end
        if ((r_state == S_SCAN) && scan.done) begin
            unique case (r_op) inside
                OP_REQUEST: begin
                    if (credit_pos && !scan.hit && scan.free) begin
                        pool_cmd = POOL_CLAIM;
                        pool_idx = free_idx;
                    end
                end
                OP_ARRIVE, OP_MISS: begin
                    if (scan.hit) begin
                        pool_cmd = POOL_RELEASE;
                    end
                end
                default: ;
            endcase
            miss_start = (r_op == OP_MISS);
        end
    end

    crwt_pool #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_pool (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (scan_start),
        .i_key      (i_packet_number),
        .i_cmd      (pool_cmd),
        .i_cmd_idx  (pool_idx),
        .i_cmd_num  (r_num),
        .o_flags    (scan),
        .o_hit_idx  (hit_idx),
        .o_free_idx (free_idx)
    );

    crwt_miss #(
        .MISS_KEEP (MISS_KEEP)
    ) u_miss (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (miss_start),
        .i_num   (r_num),
        .o_done  (miss_done),
        .o_rate  (miss_rate)
    );

    // sequencer, credits, register and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_credit         <= CREDIT_RESET;
            r_default_window <= WINDOW_RESET;
            r_o_valid        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_default_window <= i_cfg_wdata;
            end
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_operation) inside
                            OP_REQUEST, OP_ARRIVE, OP_MISS: r_state <= S_SCAN;
                            OP_ADJUST: begin
                                r_credit <= adj_sat;
                                r_state  <= S_OUT;
                            end
                            OP_RESTART: begin
                                r_credit <= CREDIT_W'(r_default_window);
                                r_state  <= S_OUT;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (scan.done) begin
                        unique case (r_op) inside
                            OP_REQUEST: begin
                                if (credit_pos && (scan.hit || scan.free)) begin
                                    r_credit <= r_credit - CREDIT_W'(1);
                                end
                            end
                            OP_ARRIVE, OP_MISS: begin
                                if (scan.hit) begin
                                    r_credit <= inc_sat;
                                end
                            end
                            default: ;
                        endcase
                        r_state <= (r_op == OP_MISS) ? S_MISS : S_OUT;
                    end
                end
                S_MISS: begin
                    if (miss_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // item payload and result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_operation;
            r_num  <= i_packet_number;
            r_acc  <= 1'b0;
            r_rate <= '0;
        end
        if ((r_state == S_SCAN) && scan.done) begin
            unique case (r_op) inside
                OP_REQUEST:         r_acc <= credit_pos && (scan.hit || scan.free);
                OP_ARRIVE, OP_MISS: r_acc <= scan.hit;
                default:            r_acc <= 1'b0;
            endcase
        end
        if ((r_state == S_MISS) && miss_done) begin
            r_rate <= miss_rate;
        end
        if ((r_state == S_OUT) && out_free) begin
            r_o_accepted  <= r_acc;
            r_o_credits   <= r_credit;
            r_o_miss_rate <= r_rate;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_accepted  = r_o_accepted;
    assign o_credits   = r_o_credits;
    assign o_miss_rate = r_o_miss_rate;

    // a scan result only arrives while the sequencer waits for it
    a_scan_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan.done |-> (r_state == S_SCAN))
        else $error("pool scan finished outside the scan state");

    a_miss_done_in_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        miss_done |-> (r_state == S_MISS))
        else $error("miss store finished outside the miss state");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_stall)
        else $error("input not held off after a transfer");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && out_free) |=> (o_valid && (r_state == S_IDLE)))
        else $error("result not presented after completion");

endmodule

// ----- hdl/crwt_pool.sv -----
// Outstanding pool: number memory, valid bits and the sequential scan.
module crwt_pool
    import crwt_pkg::*;
#(
    parameter int POOL_DEPTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [NUM_W-1:0]       i_key,
    input  t_pool_op               i_cmd,
    input  logic [AW-1:0]          i_cmd_idx,
    input  logic [NUM_W-1:0]       i_cmd_num,
    output t_scan_flags            o_flags,
    output logic [AW-1:0]          o_hit_idx,
    output logic [AW-1:0]          o_free_idx
);

    localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(POOL_DEPTH - 1);

    logic [NUM_W-1:0]      mem [POOL_DEPTH];
    logic [NUM_W-1:0]      r_rd_data;
    logic [POOL_DEPTH-1:0] r_valid;
    logic [AW-1:0]         r_rd_addr;
    logic [AW-1:0]         r_rd_idx;
    logic                  r_issuing;
    logic                  r_rd_pend;
    logic                  r_hit;
    logic                  r_free;
    logic                  r_done;
    logic [AW-1:0]         r_hit_idx;
    logic [AW-1:0]         r_free_idx;
    logic [NUM_W-1:0]      r_key;

    // number store, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd == POOL_CLAIM) begin
            mem[i_cmd_idx] <= i_cmd_num;
        end
        r_rd_data <= mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
        end
        r_rd_idx <= r_rd_addr;
        if (r_rd_pend && !r_hit && r_valid[r_rd_idx] && (r_rd_data == r_key)) begin
            r_hit_idx <= r_rd_idx;
        end
        if (r_rd_pend && !r_free && !r_valid[r_rd_idx]) begin
            r_free_idx <= r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_addr <= '0;
            r_issuing <= 1'b0;
            r_rd_pend <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            unique case (i_cmd)
                POOL_CLAIM:   r_valid[i_cmd_idx] <= 1'b1;
                POOL_RELEASE: r_valid[i_cmd_idx] <= 1'b0;
                POOL_CLEAR:   r_valid <= '0;
                default:      ;
            endcase

            r_rd_pend <= r_issuing;
            r_done    <= r_rd_pend && (r_rd_idx == LAST);

            if (r_rd_pend && !r_hit && r_valid[r_rd_idx] && (r_rd_data == r_key)) begin
                r_hit <= 1'b1;
            end
            if (r_rd_pend && !r_free && !r_valid[r_rd_idx]) begin
                r_free <= 1'b1;
            end

            if (r_issuing) begin
                if (r_rd_addr == LAST) begin
                    r_issuing <= 1'b0;
                    r_rd_addr <= '0;
                end else begin
                    r_rd_addr <= r_rd_addr + AW'(1);
                end
            end

            if (i_start) begin
                r_issuing <= 1'b1;
                r_rd_addr <= '0;
                r_hit     <= 1'b0;
                r_free    <= 1'b0;
            end
        end
    end

    assign o_flags    = '{done: r_done, hit: r_hit, free: r_free};
    assign o_hit_idx  = r_hit_idx;
    assign o_free_idx = r_free_idx;

endmodule

// ----- hdl/crwt_miss.sv -----
// Missed-number store: sorted insert and iterative count/spread quotient.
module crwt_miss
    import crwt_pkg::*;
#(
    parameter int MISS_KEEP = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    output logic              o_done,
    output logic [RATE_W-1:0] o_rate
);

    localparam int KW = $clog2(MISS_KEEP + 1);
    localparam int IW = $clog2(MISS_KEEP);
    localparam int BW = $clog2(KW);
    localparam logic [KW-1:0] KEEP = KW'(MISS_KEEP);

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_SPAN = 3'b010,
        M_DIV  = 3'b100
    } t_mstate;

    t_mstate              r_state;
    logic [NUM_W-1:0]     r_mnum [MISS_KEEP];
    logic [NUM_W-1:0]     n_mnum [MISS_KEEP];
    logic [KW-1:0]        r_mcnt;
    logic [MISS_KEEP-1:0] lt;
    logic [MISS_KEEP-1:0] eq;
    logic                 dup;
    logic                 full;
    logic [NUM_W-1:0]     r_span;
    logic [KW-1:0]        r_rem;
    logic [KW-1:0]        r_q;
    logic [BW-1:0]        r_bit;
    logic                 r_done;
    logic [RATE_W-1:0]    r_rate;
    logic [IW-1:0]        last_idx;
    logic [KW:0]          trial;
    logic [KW:0]          diff;
    logic                 ge;
    logic                 div_ok;

    // kept numbers are ascending, so lt is a thermometer code
    generate
        for (genvar j = 0; j < MISS_KEEP; j++) begin : g_cmp
            assign lt[j] = (KW'(j) < r_mcnt) && (r_mnum[j] < i_num);
            assign eq[j] = (KW'(j) < r_mcnt) && (r_mnum[j] == i_num);
        end
    endgenerate

    assign dup  = |eq;
    assign full = (r_mcnt == KEEP);

    generate
        for (genvar j = 0; j < MISS_KEEP; j++) begin : g_next
            logic lt_next;
            if (j + 1 < MISS_KEEP) begin : g_nx
                assign lt_next = lt[j+1];
            end else begin : g_nx_end
                assign lt_next = 1'b0;
            end
            if (j == 0) begin : g_first
                always_comb begin
                    if (full) begin
                        n_mnum[j] = lt_next ? r_mnum[j+1] : (lt[j] ? i_num : r_mnum[j]);
                    end else begin
                        n_mnum[j] = lt[j] ? r_mnum[j] : i_num;
                    end
                end
            end else if (j + 1 < MISS_KEEP) begin : g_mid
                always_comb begin
                    if (full) begin
                        n_mnum[j] = lt_next ? r_mnum[j+1] : (lt[j] ? i_num : r_mnum[j]);
                    end else begin
                        n_mnum[j] = lt[j] ? r_mnum[j] : (lt[j-1] ? i_num : r_mnum[j-1]);
                    end
                end
            end else begin : g_last
                always_comb begin
                    if (full) begin
                        n_mnum[j] = lt[j] ? i_num : r_mnum[j];
                    end else begin
                        n_mnum[j] = lt[j] ? r_mnum[j] : (lt[j-1] ? i_num : r_mnum[j-1]);
                    end
                end
            end
        end
    endgenerate

    assign last_idx = IW'(r_mcnt - KW'(1));
    assign trial    = {r_rem, r_mcnt[r_bit]};
    assign ge       = ({(NUM_W - KW - 1)'(0), trial} >= r_span);
    assign diff     = trial - r_span[KW:0];
    assign div_ok   = (r_mcnt > KW'(1)) && (r_span != '0);

    always_ff @(posedge i_clk) begin
        if (i_start && !dup && (!full || lt[0])) begin
            for (int k = 0; k < MISS_KEEP; k++) begin
                r_mnum[k] <= n_mnum[k];
            end
        end
        if (r_state == M_SPAN) begin
            r_span <= r_mnum[last_idx] - r_mnum[0];
            r_rem  <= '0;
            r_q    <= '0;
        end
        if (r_state == M_DIV) begin
            r_q   <= {r_q[KW-2:0], ge};
            r_rem <= ge ? diff[KW-1:0] : trial[KW-1:0];
            if (r_bit == '0) begin
                r_rate <= div_ok ? RATE_W'({r_q[KW-2:0], ge}) : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_mcnt  <= '0;
            r_bit   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        if (!dup && !full) begin
                            r_mcnt <= r_mcnt + KW'(1);
                        end
                        r_state <= M_SPAN;
                    end
                end
                M_SPAN: begin
                    r_bit   <= BW'(KW - 1);
                    r_state <= M_DIV;
                end
                M_DIV: begin
                    if (r_bit == '0) begin
                        r_done  <= 1'b1;
                        r_state <= M_IDLE;
                    end else begin
                        r_bit <= r_bit - BW'(1);
                    end
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_rate = r_rate;

endmodule
